@@ rtl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the packet ring queue
// Field widths, status codes and the front-to-back operation record.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int DATA_W   = 8;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 4;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED    = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_POP_BYTE  = 3'd3,
		ST_POP_EMPTY = 3'd4
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [DATA_W-1:0] data;
		logic              last;
	} op_t;

	// front queue head as seen by the back end
	typedef struct packed {
		logic valid;
		op_t  op;
	} op_chan_t;

endpackage

@@ rtl/prq_if.sv @@
// ----------------------------------------------------------------------------
// prq_if: channel interfaces of the packet ring queue
// Command channel into the queue and result channel out of it.
// ----------------------------------------------------------------------------
interface prq_req_if;
	import prq_pkg::*;
	logic              valid;
	logic              ready;
	logic              command;
	logic [DATA_W-1:0] push_byte;
	logic              push_last;

	modport source (output valid, command, push_byte, push_last, input ready);
	modport sink   (input valid, command, push_byte, push_last, output ready);
endinterface

interface prq_rsp_if;
	import prq_pkg::*;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   pop_byte;
	logic                pop_last;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, pop_byte, pop_last, status, occupancy, input ready);
	modport sink   (input valid, pop_byte, pop_last, status, occupancy, output ready);
endinterface

@@ rtl/prq_front.sv @@
// ----------------------------------------------------------------------------
// prq_front: command intake
// Takes request transactions, decodes them into push/pop operations and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module prq_front (
	input  logic               clk,
	input  logic               arst_n,
	prq_req_if.sink            req,
	output prq_pkg::op_chan_t  op,
	input  logic               op_take
);
	import prq_pkg::*;

	op_t        q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       accept;
	op_t        dec;

	assign req.ready = (fill_q != 2'd2);
	assign accept    = req.valid && req.ready;

	always_comb begin
		dec = '0;
		unique case (req.command)
			1'b0: begin
				dec.kind = OP_PUSH;
				dec.data = req.push_byte;
				dec.last = req.push_last;
			end
			1'b1: begin
				dec.kind = OP_POP;
			end
			default: dec = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({accept, op_take})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign op.valid = (fill_q != 2'd0);
	assign op.op    = q_mem[rd_ptr_q];

endmodule

@@ rtl/prq_back.sv @@
// ----------------------------------------------------------------------------
// prq_back: packet ring engine
// Executes push and pop operations against the slot ring, owns the byte and
// length memories and the result register.
// ----------------------------------------------------------------------------
module prq_back #(
	parameter int SLOTS      = 8,
	parameter int SLOT_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prq_pkg::op_chan_t  op,
	output logic               op_take,
	prq_rsp_if.source          rsp
);
	import prq_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int OW    = $clog2(SLOT_BYTES + 1);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int DEPTH = SLOTS * SLOT_BYTES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic {S_IDLE, S_STREAM} state_t;

	// storage
	logic [DATA_W-1:0] byte_mem [DEPTH];
	logic [OW-1:0]     len_mem  [SLOTS];
	logic [DATA_W-1:0] byte_rd_q;
	logic [OW-1:0]     len_rd_q;

	// ring state
	state_t        state_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [OW-1:0] offset_q;
	logic          dropping_q;
	logic [AW-1:0] base_q;
	logic [OW-1:0] out_idx_q;

	// result register
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_byte_q;
	logic                out_last_q;
	status_t             out_status_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic          out_free;
	logic          out_load;
	logic          idle_op;
	logic          do_push;
	logic          do_pop_empty;
	logic          do_pop_start;
	logic          stream_load;
	logic          last_byte;
	logic          drop_now;
	logic          fits;
	logic          store_wr;
	logic          len_wr;
	logic [OW-1:0] len_wr_val;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] tail_base;
	logic [AW-1:0] head_base;
	logic [CW-1:0] count_push;
	logic [SW-1:0] tail_next;
	logic [SW-1:0] head_next;
	status_t       push_status;

	assign out_free  = !out_valid_q || rsp.ready;
	assign idle_op   = (state_q == S_IDLE) && op.valid;
	assign tail_base = AW'(tail_q) * AW'(SLOT_BYTES);
	assign head_base = AW'(head_q) * AW'(SLOT_BYTES);
	assign tail_next = (tail_q == SW'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
	assign head_next = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + 1'b1;

	// a packet whose first byte finds every slot taken is discarded whole
	assign drop_now = dropping_q || (offset_q == '0 && count_q == CW'(SLOTS));
	assign fits     = offset_q < OW'(SLOT_BYTES);

	assign do_push      = idle_op && op.op.kind == OP_PUSH && out_free;
	assign do_pop_empty = idle_op && op.op.kind == OP_POP && count_q == '0 && out_free;
	assign do_pop_start = idle_op && op.op.kind == OP_POP && count_q != '0;
	assign op_take      = do_push || do_pop_empty || do_pop_start;

	assign push_status = drop_now ? ST_DROPPED : (fits ? ST_STORED : ST_TRUNC);
	assign count_push  = (!drop_now && op.op.last) ? count_q + 1'b1 : count_q;
	assign store_wr    = do_push && !drop_now && fits;
	assign len_wr      = do_push && !drop_now && op.op.last;
	assign len_wr_val  = fits ? offset_q + 1'b1 : offset_q;

	assign last_byte   = OW'(out_idx_q + 1'b1) == len_rd_q;
	assign stream_load = (state_q == S_STREAM) && out_free;
	assign rd_en       = do_pop_start || (stream_load && !last_byte);
	assign rd_addr     = do_pop_start ? head_base : base_q + AW'(out_idx_q) + 1'b1;

	// result register takes a new transaction
	assign out_load    = do_push || do_pop_empty || stream_load;

	always_ff @(posedge clk) begin
		if (store_wr) begin
			byte_mem[tail_base + AW'(offset_q)] <= op.op.data;
		end
		if (rd_en) begin
			byte_rd_q <= byte_mem[rd_addr];
		end
		if (len_wr) begin
			len_mem[tail_q] <= len_wr_val;
		end
		if (do_pop_start) begin
			len_rd_q <= len_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			offset_q     <= '0;
			dropping_q   <= 1'b0;
			base_q       <= '0;
			out_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ST_STORED;
			out_occ_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (do_push) begin
						out_byte_q   <= '0;
						out_last_q   <= 1'b0;
						out_status_q <= push_status;
						out_occ_q    <= OCC_W'(count_push);
						if (drop_now) begin
							dropping_q <= !op.op.last;
						end else if (op.op.last) begin
							tail_q   <= tail_next;
							count_q  <= count_push;
							offset_q <= '0;
						end else if (fits) begin
							offset_q <= offset_q + 1'b1;
						end
					end else if (do_pop_empty) begin
						out_byte_q   <= '0;
						out_last_q   <= 1'b0;
						out_status_q <= ST_POP_EMPTY;
						out_occ_q    <= OCC_W'(count_q);
					end else if (do_pop_start) begin
						head_q    <= head_next;
						count_q   <= count_q - 1'b1;
						base_q    <= head_base;
						out_idx_q <= '0;
						state_q   <= S_STREAM;
					end
				end
				S_STREAM: begin
					if (stream_load) begin
						out_byte_q   <= byte_rd_q;
						out_last_q   <= last_byte;
						out_status_q <= ST_POP_BYTE;
						out_occ_q    <= OCC_W'(count_q);
						out_idx_q    <= out_idx_q + 1'b1;
						if (last_byte) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pop_byte  = out_byte_q;
	assign rsp.pop_last  = out_last_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("packet count above slot count");

	a_empty_ring: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == tail_q)
		else $error("empty ring with head and tail apart");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dropping_q |-> offset_q == '0)
		else $error("dropping a packet that has stored bytes");

	a_pop_enters_stream: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop_start |=> state_q == S_STREAM && len_rd_q != '0)
		else $error("pop of a held packet did not start streaming");

	a_stream_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STREAM |-> out_idx_q < len_rd_q)
		else $error("stream index past packet length");

endmodule

@@ rtl/packet_ring_queue_top.sv @@
// ----------------------------------------------------------------------------
// packet_ring_queue_top: variable-length packet ring queue
// Stores packets byte by byte into a ring of fixed-size slots and replays
// the oldest packet on a pop command.
// ----------------------------------------------------------------------------
//
//  channel | dir | transaction carries               | per transaction
//  --------+-----+-----------------------------------+-------------------------
//  req     | in  | command, push_byte, push_last     | one push byte or one pop
//  rsp     | out | pop_byte, pop_last, status,       | one per push, one per
//          |     | occupancy                         | popped byte, one on empty
//
// Flow: a push and a pop on an empty ring are each done by the back end straight
// from its idle state and run back to back. A pop of an N-byte packet first
// reads the slot length and the first byte out of the byte memory, then one
// byte per cycle follows from its single read port while rsp is not stalled.
// Reset: arst_n clears the ring pointers, the packet count, the build state
// and both handshakes at once. Byte and length memories are not cleared;
// a slot is only read after a packet was written into it.
// Stalls: a two-entry request queue sits between intake and engine, so req
// keeps taking transactions while a pop streams, until the queue fills. A
// stalled rsp holds the engine; the result register frees as it is taken.
//
module packet_ring_queue_top #(
	parameter int SLOTS      = 8,   // packet slots in the ring, 2 to 15
	parameter int SLOT_BYTES = 32   // bytes per slot, 4 to 64
) (
	input  logic      clk,
	input  logic      arst_n,
	prq_req_if.sink   req,
	prq_rsp_if.source rsp
);
	import prq_pkg::*;

	// operation at the head of the intake queue, and its pop strobe
	op_chan_t op;
	logic     op_take;

	// intake: decode and buffer request transactions
	prq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.op      (op),
		.op_take (op_take)
	);

	// engine: ring bookkeeping, memories and the result register
	prq_back #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.op_take (op_take),
		.rsp     (rsp)
	);

endmodule
